// ===== hw/rtl/cse_pkg.sv =====
`default_nettype none
package cse_pkg;

  localparam int CSE_WINDOW = 64;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_D1,
    S_D2,
    S_SQ1,
    S_SQ2,
    S_ACC,
    S_Z,
    S_T1,
    S_T2,
    S_T3,
    S_M1,
    S_M2,
    S_M3,
    S_L1,
    S_L2,
    S_L3,
    S_U1,
    S_U2,
    S_U3,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_ON   = 2'd1,
    EDGE_OFF  = 2'd2
  } edge_t;

  typedef enum logic [2:0] {
    CFG_GAIN_RED    = 3'd0,
    CFG_GAIN_GREEN  = 3'd1,
    CFG_GAIN_BLUE   = 3'd2,
    CFG_GAIN_SPREAD = 3'd3,
    CFG_OFFSET_RGB  = 3'd4,
    CFG_OFFSET_SPRD = 3'd5,
    CFG_MIX_RGB     = 3'd6,
    CFG_DECAY_RATE  = 3'd7
  } cfg_idx_t;

  localparam logic signed [15:0] GAIN_RESET = 16'sd4096;
  localparam logic [12:0]        MIX_RESET  = 13'd4096;
  localparam logic [15:0]        RATE_RESET = 16'd6554;

  localparam logic signed [19:0] LVL_HALF = 20'sd8192;
  localparam logic signed [19:0] LVL_ONE  = 20'sd16384;
  localparam logic signed [19:0] LVL_MAX  = 20'sd32767;
  localparam logic signed [19:0] LVL_MIN  = -20'sd32768;
  localparam logic signed [15:0] ON_LIMIT = 16'sd8192;

  localparam logic [14:0] TANH_ONE = 15'd16384;

  // tanh(k/4) in Q1.14
  function automatic logic [14:0] tanh_tab(input logic [4:0] k);
    logic [14:0] v;
    case (k)
      5'd0:  v = 15'd0;
      5'd1:  v = 15'd4013;
      5'd2:  v = 15'd7571;
      5'd3:  v = 15'd10406;
      5'd4:  v = 15'd12478;
      5'd5:  v = 15'd13898;
      5'd6:  v = 15'd14830;
      5'd7:  v = 15'd15423;
      5'd8:  v = 15'd15795;
      5'd9:  v = 15'd16024;
      5'd10: v = 15'd16165;
      5'd11: v = 15'd16251;
      5'd12: v = 15'd16303;
      5'd13: v = 15'd16335;
      5'd14: v = 15'd16354;
      5'd15: v = 15'd16366;
      5'd16: v = 15'd16373;
      5'd17: v = 15'd16377;
      5'd18: v = 15'd16380;
      5'd19: v = 15'd16382;
      5'd20: v = 15'd16383;
      5'd21: v = 15'd16383;
      5'd22: v = 15'd16383;
      default: v = TANH_ONE;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cse_sample_if.sv =====
`default_nettype none
interface cse_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] red;
  logic signed [15:0] green;
  logic signed [15:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cse_result_if.sv =====
`default_nettype none
interface cse_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         edge_event;
  logic               switch_on;
  logic signed [15:0] level;

  modport source (output valid, output edge_event, output switch_on, output level,
                  input ready);
  modport sink (input valid, input edge_event, input switch_on, input level,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cse_cfg_if.sv =====
`default_nettype none
interface cse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cse_ram.sv =====
`default_nettype none
module cse_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/color_switch_event_detector.sv =====
`default_nettype none
// Color switch event detector. Each transfer on sample carries one red/green/blue
// sample in Q8.8; each produces exactly one transfer on result with the edge event
// (0 none, 1 switched on, 2 switched off), the binarized level and the smoothed
// level in Q1.14. The spread feature is the sum of the three channel standard
// deviations over the previous WINDOW samples; for the first WINDOW samples the
// block only stores the sample and adds it to the channel sums, and reports the
// held level with no event. Once the window is full, each channel's standard
// deviation comes from a 16-step bitwise root search that squares the scaled trial
// root on the shared multiplier, one root bit per pass, and the same multiplier
// serves the tanh interpolation, the mix and the level update.
// The next sample is taken while the previous result waits. Registers are written
// through cfg at any index 0..7 and are accepted every cycle; write them only while
// the block is idle. The history lives in one memory of WINDOW words of 48 bits
// and needs no clearing after reset.
module color_switch_event_detector
  import cse_pkg::*;
#(
  parameter int WINDOW = CSE_WINDOW
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cse_sample_if.sink   sample,
  cse_result_if.source result,
  cse_cfg_if.sink      cfg
);

  localparam int LOGW  = $clog2(WINDOW);
  localparam int AW    = (LOGW < 1) ? 1 : LOGW;
  localparam int WCW   = $clog2(WINDOW + 1);
  localparam int SUM_W = 17 + LOGW;
  localparam int SQ_W  = 31 + LOGW;
  localparam int DW    = 31 + 2 * LOGW;
  localparam int MW    = (SUM_W > 20) ? SUM_W : 20;
  localparam int PW    = 2 * MW;

  // configuration registers
  logic signed [15:0] gain_red, gain_green, gain_blue, gain_spread;
  logic signed [15:0] offset_rgb, offset_spread;
  logic [12:0]        mix_rgb;
  logic [15:0]        decay_rate;

  // block state
  state_t                    state, state_next;
  logic [AW-1:0]             wr_pos;
  logic [WCW-1:0]            warm_cnt;
  logic signed [SUM_W-1:0]   sum_q [3];
  logic [SQ_W-1:0]           sq_q [3];
  logic signed [15:0]        level_q;
  logic                      prev_on;

  // datapath registers
  logic signed [15:0]  x_q [3];
  logic signed [15:0]  old_q [3];
  logic signed [15:0]  t_q [4];
  logic [1:0]          sel;
  logic [4:0]          cnt;
  logic signed [PW-1:0] prod_q, acc_q;
  logic [DW-1:0]       nsq_q;
  logic [DW-1:0]       d_q;
  logic [MW-1:0]       tw_q;
  logic [MW-1:0]       step_q;
  logic [15:0]         root_q;
  logic [17:0]         spread_q;
  logic [PW-1:0]       a_q;
  logic                neg_q;
  logic [14:0]         base_q;
  logic                big_q;
  logic signed [19:0]  mixed_q;
  edge_t               edge_q;

  // result register
  logic               res_valid;
  edge_t              res_edge;
  logic               res_on;
  logic signed [15:0] res_level;

  logic [47:0] ram_rdata;
  logic        ram_we;
  logic        warm;
  logic        in_fire, out_fire, done_fire;

  logic signed [MW-1:0] mul_a, mul_b;

  assign warm      = (warm_cnt == WCW'(WINDOW));
  assign in_fire   = sample.valid && sample.ready;
  assign out_fire  = result.valid && result.ready;
  assign done_fire = (state == S_DONE) && (!res_valid || result.ready);
  assign ram_we    = done_fire;

  assign sample.ready      = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign result.valid      = res_valid;
  assign result.edge_event = res_edge;
  assign result.switch_on  = res_on;
  assign result.level      = res_level;

  cse_ram #(
    .WIDTH (48),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos),
    .wdata ({x_q[2], x_q[1], x_q[0]}),
    .raddr (wr_pos),
    .rdata (ram_rdata)
  );

  // combinational helpers
  logic [SUM_W-1:0]     mag;
  logic [DW-1:0]        dval;
  logic [MW-1:0]        t_try;
  logic                 sq_ok;
  logic signed [15:0]   gain_sel, ofs_sel;
  logic signed [PW-1:0] zval;
  logic [14:0]          tab_hi, tab_lo, tab_d;
  logic signed [PW-1:0] trnd;
  logic [14:0]          yval;
  logic signed [17:0]   tsum;
  logic signed [16:0]   spread_w;
  logic [16:0]          inv_rate;
  logic signed [PW-1:0] msum, usum;
  logic signed [19:0]   upd, lvl;
  logic signed [15:0]   lvl_sat;
  logic                 on_next;

  always_comb begin
    mag = sum_q[sel][SUM_W-1] ? SUM_W'(-sum_q[sel]) : SUM_W'(sum_q[sel]);
    dval = nsq_q - prod_q[DW-1:0];
    // trial root scaled by the window, its square is checked against the deviation sum
    t_try = tw_q + step_q;
    sq_ok = (PW'(d_q) >= prod_q[PW-1:0]);

    case (sel)
      2'd0:    gain_sel = gain_red;
      2'd1:    gain_sel = gain_green;
      2'd2:    gain_sel = gain_blue;
      default: gain_sel = gain_spread;
    endcase
    ofs_sel = (sel == 2'd3) ? offset_spread : offset_rgb;
    zval = prod_q + (PW'(ofs_sel) <<< 8);

    tab_lo = tanh_tab(a_q[22:18]);
    tab_hi = tanh_tab(a_q[22:18] + 5'd1);
    tab_d  = tab_hi - tab_lo;
    trnd   = prod_q + PW'(1 << 17);
    yval   = big_q ? TANH_ONE : base_q + trnd[32:18];

    tsum     = 18'(t_q[0]) + 18'(t_q[1]) + 18'(t_q[2]);
    spread_w = 17'sd16384 - signed'(17'(mix_rgb) * 17'd3);
    inv_rate = 17'h10000 - 17'(decay_rate);

    msum = acc_q + prod_q + PW'(8192);
    usum = acc_q + prod_q + PW'(32768);
    upd  = usum[35:16];
    if (mixed_q > LVL_HALF) begin
      lvl = LVL_ONE;
    end else begin
      lvl = (mixed_q > upd) ? mixed_q : upd;
    end
    if (lvl > LVL_MAX) begin
      lvl_sat = 16'sd32767;
    end else if (lvl < LVL_MIN) begin
      lvl_sat = -16'sd32768;
    end else begin
      lvl_sat = lvl[15:0];
    end
    on_next = (lvl_sat > ON_LIMIT);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_D1: begin
        mul_a = signed'(MW'(mag));
        mul_b = signed'(MW'(mag));
      end
      S_SQ1: begin
        mul_a = signed'(t_try);
        mul_b = signed'(t_try);
      end
      S_Z: begin
        mul_a = MW'(gain_sel);
        mul_b = (sel == 2'd3) ? signed'(MW'(spread_q)) : MW'(x_q[sel]);
      end
      S_T2: begin
        mul_a = signed'(MW'(tab_d));
        mul_b = signed'(MW'(a_q[17:0]));
      end
      S_M1: begin
        mul_a = signed'(MW'(mix_rgb));
        mul_b = MW'(tsum);
      end
      S_M2: begin
        mul_a = MW'(spread_w);
        mul_b = MW'(t_q[3]);
      end
      S_L1: begin
        mul_a = MW'(mixed_q);
        mul_b = signed'(MW'(decay_rate));
      end
      S_L2: begin
        mul_a = MW'(level_q);
        mul_b = signed'(MW'(inv_rate));
      end
      S_U1: begin
        mul_a = MW'(x_q[sel]);
        mul_b = MW'(x_q[sel]);
      end
      S_U2: begin
        mul_a = MW'(old_q[sel]);
        mul_b = MW'(old_q[sel]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_fire) state_next = S_RD;
      S_RD:    state_next = warm ? S_D1 : S_U1;
      S_D1:    state_next = S_D2;
      S_D2:    state_next = S_SQ1;
      S_SQ1:   state_next = S_SQ2;
      S_SQ2:   state_next = (cnt == 5'd15) ? S_ACC : S_SQ1;
      S_ACC:   state_next = (sel == 2'd2) ? S_Z : S_D1;
      S_Z:     state_next = S_T1;
      S_T1:    state_next = S_T2;
      S_T2:    state_next = S_T3;
      S_T3:    state_next = (sel == 2'd3) ? S_M1 : S_Z;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_L1;
      S_L1:    state_next = S_L2;
      S_L2:    state_next = S_L3;
      S_L3:    state_next = S_U1;
      S_U1:    state_next = S_U2;
      S_U2:    state_next = S_U3;
      S_U3:    state_next = (sel == 2'd2) ? S_DONE : S_U1;
      S_DONE:  if (done_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_red      <= GAIN_RESET;
      gain_green    <= GAIN_RESET;
      gain_blue     <= GAIN_RESET;
      gain_spread   <= GAIN_RESET;
      offset_rgb    <= '0;
      offset_spread <= '0;
      mix_rgb       <= MIX_RESET;
      decay_rate    <= RATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_GAIN_RED:    gain_red      <= cfg.data;
        CFG_GAIN_GREEN:  gain_green    <= cfg.data;
        CFG_GAIN_BLUE:   gain_blue     <= cfg.data;
        CFG_GAIN_SPREAD: gain_spread   <= cfg.data;
        CFG_OFFSET_RGB:  offset_rgb    <= cfg.data;
        CFG_OFFSET_SPRD: offset_spread <= cfg.data;
        CFG_MIX_RGB:     mix_rgb       <= cfg.data[12:0];
        CFG_DECAY_RATE:  decay_rate    <= cfg.data;
        default: ;
      endcase
    end
  end

  // persistent state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos    <= '0;
      warm_cnt  <= '0;
      level_q   <= '0;
      prev_on   <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        sq_q[i]  <= '0;
      end
    end else begin
      if (state == S_L3) begin
        level_q <= lvl_sat;
        prev_on <= on_next;
      end
      if (state == S_U3) begin
        sq_q[sel]  <= sq_q[sel] + acc_q[SQ_W-1:0] - prod_q[SQ_W-1:0];
        sum_q[sel] <= sum_q[sel] + SUM_W'(x_q[sel]) - SUM_W'(old_q[sel]);
      end
      if (done_fire) begin
        wr_pos <= (wr_pos == AW'(WINDOW - 1)) ? '0 : wr_pos + 1'b1;
        if (!warm) begin
          warm_cnt <= warm_cnt + 1'b1;
        end
        res_valid <= 1'b1;
      end else if (out_fire) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          x_q[0] <= sample.red;
          x_q[1] <= sample.green;
          x_q[2] <= sample.blue;
        end
        edge_q <= EDGE_NONE;
        sel    <= '0;
      end
      S_RD: begin
        for (int i = 0; i < 3; i++) begin
          old_q[i] <= warm ? signed'(ram_rdata[16*i +: 16]) : 16'sd0;
        end
        spread_q <= '0;
      end
      S_D1: begin
        nsq_q <= DW'(sq_q[sel]) * DW'(WINDOW);
      end
      S_D2: begin
        d_q    <= dval;
        tw_q   <= '0;
        step_q <= MW'(WINDOW) << 15;
        root_q <= '0;
        cnt    <= '0;
      end
      S_SQ2: begin
        // root bits settle from the top, one per pass
        root_q <= {root_q[14:0], sq_ok};
        if (sq_ok) begin
          tw_q <= t_try;
        end
        step_q <= step_q >> 1;
        cnt    <= cnt + 5'd1;
      end
      S_ACC: begin
        spread_q <= spread_q + 18'(root_q);
        sel      <= (sel == 2'd2) ? 2'd0 : sel + 2'd1;
      end
      S_T1: begin
        neg_q <= zval[PW-1];
        a_q   <= zval[PW-1] ? PW'(-zval) : PW'(zval);
      end
      S_T2: begin
        base_q <= tab_lo;
        big_q  <= (a_q[PW-1:18] >= (PW-18)'(24));
      end
      S_T3: begin
        t_q[sel] <= neg_q ? -signed'(16'(yval)) : signed'(16'(yval));
        sel      <= sel + 2'd1;
      end
      S_M2: begin
        acc_q <= prod_q;
      end
      S_M3: begin
        mixed_q <= msum[33:14];
      end
      S_L2: begin
        acc_q <= prod_q;
      end
      S_L3: begin
        if (on_next && !prev_on) begin
          edge_q <= EDGE_ON;
        end else if (!on_next && prev_on) begin
          edge_q <= EDGE_OFF;
        end else begin
          edge_q <= EDGE_NONE;
        end
      end
      S_U2: begin
        acc_q <= prod_q;
      end
      S_U3: begin
        sel <= (sel == 2'd2) ? 2'd0 : sel + 2'd1;
      end
      S_DONE: begin
        if (done_fire) begin
          res_edge  <= edge_q;
          res_on    <= prev_on;
          res_level <= level_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
